/* hdl/pnc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_pkg: shared types and constants of the polygon normal and centroid block
// Holds the fixed widths of the normal arithmetic and the controller to
// datapath command and status words.
// ----------------------------------------------------------------------------
package pnc_pkg;

	localparam int ACC_W       = 64;  // Newell accumulators wrap at 64 bits
	localparam int MAG_LIM_BIT = 31;  // magnitudes are scaled below 2^31
	localparam int LEN_W       = 32;  // width of the vector length
	localparam int SQRT_STEPS  = 32;  // one result bit per step
	localparam int NORM_W      = 16;
	localparam int NORM_FRAC   = 15;
	localparam int MIN_VERTICES = 3;
	localparam logic [NORM_W-1:0] NORM_MAX = 16'd32767;

	typedef struct packed {
		logic       load_vtx;
		logic       term_mul;
		logic       term_close;
		logic       term_add;
		logic       commit;
		logic       mag_load;
		logic       shift_step;
		logic       sq_mul;
		logic       sq_add;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       ndiv_init;
		logic       cdiv_init;
		logic       div_step;
		logic       nstore;
		logic       cstore;
		logic       out_load;
		logic [1:0] idx;
	} pnc_cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic last;
		logic need_shift;
	} pnc_status_t;

endpackage
`default_nettype wire

/* hdl/pnc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_datapath: polygon state, shared multiplier, square root and divider
// Executes one command word per cycle and holds the output word registers.
// ----------------------------------------------------------------------------
module pnc_datapath
	import pnc_pkg::*;
#(
	parameter int MAX_POLYGON_VERTICES = 256,
	parameter int COORD_WIDTH          = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pnc_cmd_t                      cmd,
	output pnc_status_t                        status,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	input  wire logic                          last_vertex,
	output logic signed [NORM_W-1:0]           normal_x,
	output logic signed [NORM_W-1:0]           normal_y,
	output logic signed [NORM_W-1:0]           normal_z,
	output logic signed [COORD_WIDTH-1:0]      centroid_x,
	output logic signed [COORD_WIDTH-1:0]      centroid_y,
	output logic signed [COORD_WIDTH-1:0]      centroid_z,
	output logic                               degenerate,
	output logic                               overflow
);

	localparam int CW     = COORD_WIDTH;
	localparam int CNT_W  = $clog2(MAX_POLYGON_VERTICES + 1);
	localparam int SUM_W  = CW + CNT_W;
	localparam int MUL_W  = (CW + 1 > 32) ? CW + 1 : 32;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
	localparam int NW     = (SUM_W + 1 > 48) ? SUM_W + 1 : 48;

	logic signed [CW-1:0]     cur_q   [3];
	logic signed [CW-1:0]     first_q [3];
	logic signed [CW-1:0]     prev_q  [3];
	logic                     last_q;
	logic signed [ACC_W-1:0]  acc_q   [3];
	logic signed [SUM_W-1:0]  sum_q   [3];
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]         mag_q   [3];
	logic [2:0]               neg_q;
	logic [ACC_W-1:0]         sq_q;
	logic [ACC_W-1:0]         v_q, r_q, b_q;
	logic [NW-1:0]            num_q, quo_q;
	logic [DIV_W:0]           rem_q;
	logic [DIV_W-1:0]         den_q;
	logic                     cneg_q;
	logic signed [NORM_W-1:0] nrm_q   [3];
	logic signed [CW-1:0]     cen_q   [3];

	logic signed [CW-1:0]  tb [3];
	logic signed [CW:0]    dif, add;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic [ACC_W-1:0]      mag_sel, or_m, rb;
	logic                  neg_sel;
	logic signed [SUM_W-1:0] sum_sel;
	logic [SUM_W-1:0]      smag;
	logic [LEN_W-1:0]      len;
	logic                  degen;
	logic [DIV_W:0]        rsh;
	logic [NORM_W-1:0]     sat;
	logic [CW-1:0]         cq;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tb[i] = cmd.term_close ? first_q[i] : cur_q[i];
		end
		unique case (cmd.idx)
			2'd0: begin
				dif = (CW+1)'(prev_q[1]) - (CW+1)'(tb[1]);
				add = (CW+1)'(prev_q[2]) + (CW+1)'(tb[2]);
			end
			2'd1: begin
				dif = (CW+1)'(prev_q[2]) - (CW+1)'(tb[2]);
				add = (CW+1)'(prev_q[0]) + (CW+1)'(tb[0]);
			end
			2'd2: begin
				dif = (CW+1)'(prev_q[0]) - (CW+1)'(tb[0]);
				add = (CW+1)'(prev_q[1]) + (CW+1)'(tb[1]);
			end
			default: begin
				dif = '0;
				add = '0;
			end
		endcase
		unique case (cmd.idx)
			2'd1: begin
				mag_sel = mag_q[1];
				neg_sel = neg_q[1];
				sum_sel = sum_q[1];
			end
			2'd2: begin
				mag_sel = mag_q[2];
				neg_sel = neg_q[2];
				sum_sel = sum_q[2];
			end
			default: begin
				mag_sel = mag_q[0];
				neg_sel = neg_q[0];
				sum_sel = sum_q[0];
			end
		endcase
		if (cmd.sq_mul) begin
			mul_a = signed'(MUL_W'(mag_sel[MAG_LIM_BIT-1:0]));
			mul_b = mul_a;
		end else begin
			mul_a = MUL_W'(dif);
			mul_b = MUL_W'(add);
		end
		or_m  = mag_q[0] | mag_q[1] | mag_q[2];
		smag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
		len   = r_q[LEN_W-1:0];
		degen = (cnt_q < CNT_W'(MIN_VERTICES)) || (len == '0);
		rb    = r_q + b_q;
		rsh   = {rem_q[DIV_W-1:0], num_q[NW-1]};
		sat   = (quo_q > NW'(NORM_MAX)) ? NORM_MAX : quo_q[NORM_W-1:0];
		cq    = quo_q[CW-1:0];
	end

	assign status.cnt_zero   = (cnt_q == '0);
	assign status.cnt_full   = (cnt_q == CNT_W'(MAX_POLYGON_VERTICES));
	assign status.last       = last_q;
	assign status.need_shift = |or_m[ACC_W-1:MAG_LIM_BIT];

	// Polygon state: reset and cleared after every result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				first_q[i] <= '0;
				prev_q[i]  <= '0;
				acc_q[i]   <= '0;
				sum_q[i]   <= '0;
			end
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_load) begin
			for (int i = 0; i < 3; i++) begin
				first_q[i] <= '0;
				prev_q[i]  <= '0;
				acc_q[i]   <= '0;
				sum_q[i]   <= '0;
			end
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.term_add) begin
				for (int i = 0; i < 3; i++) begin
					if (cmd.idx == 2'(i)) begin
						acc_q[i] <= acc_q[i] + ACC_W'(prod_q);
					end
				end
			end
			if (cmd.commit) begin
				if (status.cnt_full) begin
					ovf_q <= 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (status.cnt_zero) begin
							first_q[i] <= cur_q[i];
						end
						prev_q[i] <= cur_q[i];
						sum_q[i]  <= sum_q[i] + SUM_W'(cur_q[i]);
					end
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Working registers of the normal and centroid arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.load_vtx) begin
			cur_q[0] <= pos_x;
			cur_q[1] <= pos_y;
			cur_q[2] <= pos_z;
			last_q   <= last_vertex;
		end
		if (cmd.term_mul || cmd.sq_mul) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.mag_load) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= acc_q[i][ACC_W-1];
				mag_q[i] <= acc_q[i][ACC_W-1] ? ACC_W'(-acc_q[i]) : ACC_W'(acc_q[i]);
			end
			sq_q <= '0;
		end
		if (cmd.shift_step) begin
			for (int i = 0; i < 3; i++) begin
				mag_q[i] <= mag_q[i] >> 1;
			end
		end
		if (cmd.sq_add) begin
			sq_q <= sq_q + ACC_W'(unsigned'(prod_q));
		end
		if (cmd.sqrt_init) begin
			v_q <= sq_q;
			r_q <= '0;
			b_q <= ACC_W'(1) << (ACC_W - 2);
		end
		if (cmd.sqrt_step) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
		if (cmd.ndiv_init) begin
			num_q <= NW'({mag_sel[MAG_LIM_BIT-1:0], NORM_FRAC'(0)}) + NW'(len >> 1);
			den_q <= DIV_W'(len);
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.cdiv_init) begin
			num_q  <= NW'(smag) + NW'(cnt_q >> 1);
			den_q  <= DIV_W'(cnt_q);
			rem_q  <= '0;
			quo_q  <= '0;
			cneg_q <= sum_sel[SUM_W-1];
		end
		if (cmd.div_step) begin
			if (rsh >= {1'b0, den_q}) begin
				rem_q <= rsh - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rsh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
			num_q <= num_q << 1;
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.nstore && cmd.idx == 2'(i)) begin
				nrm_q[i] <= neg_sel ? signed'(-sat) : signed'(sat);
			end
			if (cmd.cstore && cmd.idx == 2'(i)) begin
				cen_q[i] <= cneg_q ? signed'(-cq) : signed'(cq);
			end
		end
		if (cmd.out_load) begin
			normal_x   <= degen ? '0 : nrm_q[0];
			normal_y   <= degen ? '0 : nrm_q[1];
			normal_z   <= degen ? '0 : nrm_q[2];
			centroid_x <= cen_q[0];
			centroid_y <= cen_q[1];
			centroid_z <= cen_q[2];
			degenerate <= degen;
			overflow   <= ovf_q;
		end
	end

endmodule
`default_nettype wire

/* hdl/pnc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnc_ctrl: sequencer of the polygon normal and centroid block
// Steps the datapath through vertex accumulation, closing, scaling, square
// root and the divisions, and owns both handshakes.
// ----------------------------------------------------------------------------
module pnc_ctrl
	import pnc_pkg::*;
#(
	parameter int MAX_POLYGON_VERTICES = 256,
	parameter int COORD_WIDTH          = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	input  wire pnc_status_t status,
	output pnc_cmd_t         cmd
);

	localparam int CNT_W = $clog2(MAX_POLYGON_VERTICES + 1);
	localparam int SUM_W = COORD_WIDTH + CNT_W;
	localparam int NW    = (SUM_W + 1 > 48) ? SUM_W + 1 : 48;
	localparam int IT_W  = $clog2(NW + 1);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_TMUL      = 5'd1;
	localparam logic [4:0] S_TADD      = 5'd2;
	localparam logic [4:0] S_COMMIT    = 5'd3;
	localparam logic [4:0] S_CMUL      = 5'd4;
	localparam logic [4:0] S_CADD      = 5'd5;
	localparam logic [4:0] S_MAG       = 5'd6;
	localparam logic [4:0] S_SHIFT     = 5'd7;
	localparam logic [4:0] S_SQMUL     = 5'd8;
	localparam logic [4:0] S_SQADD     = 5'd9;
	localparam logic [4:0] S_SQRT_INIT = 5'd10;
	localparam logic [4:0] S_SQRT      = 5'd11;
	localparam logic [4:0] S_NDIV_INIT = 5'd12;
	localparam logic [4:0] S_NDIV      = 5'd13;
	localparam logic [4:0] S_NSTORE    = 5'd14;
	localparam logic [4:0] S_CDIV_INIT = 5'd15;
	localparam logic [4:0] S_CDIV      = 5'd16;
	localparam logic [4:0] S_CSTORE    = 5'd17;
	localparam logic [4:0] S_OUT       = 5'd18;

	logic [4:0]      state_q, state_d;
	logic [1:0]      idx_q, idx_d;
	logic [IT_W-1:0] iter_q, iter_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.idx = idx_q;
		state_d = state_q;
		idx_d   = idx_q;
		iter_d  = iter_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_vtx = 1'b1;
					idx_d        = 2'd0;
					state_d      = (status.cnt_zero || status.cnt_full) ? S_COMMIT : S_TMUL;
				end
			end
			S_TMUL: begin
				cmd.term_mul = 1'b1;
				state_d      = S_TADD;
			end
			S_TADD: begin
				cmd.term_add = 1'b1;
				if (idx_q == 2'd2) begin
					state_d = S_COMMIT;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_TMUL;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				idx_d      = 2'd0;
				state_d    = status.last ? S_CMUL : S_IDLE;
			end
			S_CMUL: begin
				cmd.term_mul   = 1'b1;
				cmd.term_close = 1'b1;
				state_d        = S_CADD;
			end
			S_CADD: begin
				cmd.term_add = 1'b1;
				if (idx_q == 2'd2) begin
					state_d = S_MAG;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_CMUL;
				end
			end
			S_MAG: begin
				cmd.mag_load = 1'b1;
				state_d      = S_SHIFT;
			end
			S_SHIFT: begin
				if (status.need_shift) begin
					cmd.shift_step = 1'b1;
				end else begin
					idx_d   = 2'd0;
					state_d = S_SQMUL;
				end
			end
			S_SQMUL: begin
				cmd.sq_mul = 1'b1;
				state_d    = S_SQADD;
			end
			S_SQADD: begin
				cmd.sq_add = 1'b1;
				if (idx_q == 2'd2) begin
					state_d = S_SQRT_INIT;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_SQMUL;
				end
			end
			S_SQRT_INIT: begin
				cmd.sqrt_init = 1'b1;
				iter_d        = IT_W'(SQRT_STEPS);
				state_d       = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q - 1'b1;
				if (iter_q == IT_W'(1)) begin
					idx_d   = 2'd0;
					state_d = S_NDIV_INIT;
				end
			end
			S_NDIV_INIT: begin
				cmd.ndiv_init = 1'b1;
				iter_d        = IT_W'(NW);
				state_d       = S_NDIV;
			end
			S_NDIV: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - 1'b1;
				if (iter_q == IT_W'(1)) begin
					state_d = S_NSTORE;
				end
			end
			S_NSTORE: begin
				cmd.nstore = 1'b1;
				state_d    = S_CDIV_INIT;
			end
			S_CDIV_INIT: begin
				cmd.cdiv_init = 1'b1;
				iter_d        = IT_W'(NW);
				state_d       = S_CDIV;
			end
			S_CDIV: begin
				cmd.div_step = 1'b1;
				iter_d       = iter_q - 1'b1;
				if (iter_q == IT_W'(1)) begin
					state_d = S_CSTORE;
				end
			end
			S_CSTORE: begin
				cmd.cstore = 1'b1;
				if (idx_q == 2'd2) begin
					state_d = S_OUT;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = S_NDIV_INIT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= 2'd0;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			iter_q  <= iter_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result word loaded over a word still waiting");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_TMUL || state_q == S_COMMIT))
		else $error("accepted vertex not taken into accumulation");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result word appeared outside the output step");

	a_iter_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NDIV || state_q == S_CDIV || state_q == S_SQRT) |-> (iter_q != '0))
		else $error("iteration counter ran out inside a loop");

endmodule
`default_nettype wire

/* hdl/polygon_normal_centroid.sv */
`timescale 1ns / 1ps
`default_nettype none
// A vertex after the first: an accept in S_IDLE, then a multiply and an add for each Newell term, and a commit.
// The first vertex of a polygon, and a vertex dropped past the limit, go from the accept straight to the commit.
// Last vertex: those steps, then the closing terms, the magnitude load and scaling shifts, the squares, the root,
// the normal and centroid divisions of each axis (NW = 48 at default widths) and the output load.
// The serial square root and the one-bit-a-cycle divider set the per-polygon cost.
// Reset (arst_n low) empties the polygon state and drops any waiting result word.
// ----------------------------------------------------------------------------
// polygon_normal_centroid: Newell polygon normal and vertex centroid
// Streams polygon vertices, accumulates the Newell cross terms and coordinate
// sums, and on the last vertex returns the unit normal and the centroid.
// ----------------------------------------------------------------------------
module polygon_normal_centroid
	import pnc_pkg::*;
#(
	parameter int MAX_POLYGON_VERTICES = 256,
	parameter int COORD_WIDTH          = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	input  wire logic                          last_vertex,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [NORM_W-1:0]           normal_x,
	output logic signed [NORM_W-1:0]           normal_y,
	output logic signed [NORM_W-1:0]           normal_z,
	output logic signed [COORD_WIDTH-1:0]      centroid_x,
	output logic signed [COORD_WIDTH-1:0]      centroid_y,
	output logic signed [COORD_WIDTH-1:0]      centroid_z,
	output logic                               degenerate,
	output logic                               overflow
);

	// The controller issues one command word per cycle; the datapath reports
	// whether the vertex count is empty or full, the last flag and whether
	// the magnitudes still need scaling. The result word sits in its own
	// output registers, so new vertices are accepted while it waits to be taken.
	pnc_cmd_t    cmd;
	pnc_status_t status;

	pnc_ctrl #(
		.MAX_POLYGON_VERTICES (MAX_POLYGON_VERTICES),
		.COORD_WIDTH          (COORD_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the first and previous vertex, the three wrapping
	// Newell accumulators, the coordinate sums, the count and the overflow mark.
	// A vertex beyond the maximum count is dropped but marks the overflow.
	pnc_datapath #(
		.MAX_POLYGON_VERTICES (MAX_POLYGON_VERTICES),
		.COORD_WIDTH          (COORD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.last_vertex (last_vertex),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.centroid_z  (centroid_z),
		.degenerate  (degenerate),
		.overflow    (overflow)
	);

endmodule
`default_nettype wire
